FILE: sv/ptts_pkg.sv
package ptts_pkg;

    localparam int SLOTS       = 8;
    localparam int LOAD_WINDOW = 8;
    localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SCNT_W      = $clog2(SLOTS + 1);
    localparam int LPOS_W      = (LOAD_WINDOW > 1) ? $clog2(LOAD_WINDOW) : 1;
    localparam int SUM_W       = $clog2(LOAD_WINDOW * SLOTS + 1);
    localparam int PRIO_W      = 6;
    localparam int ENTRY_W     = 32 + 32 + PRIO_W + 1 + 32;
    localparam logic signed [PRIO_W-1:0] NO_WIN_PRIORITY = PRIO_W'(20);
    localparam logic [31:0] ELAPSED_MAX = 32'hFFFF_FFFF;
    localparam logic [23:0] HEARTBEAT_RESET = 24'd1000;

    typedef enum logic [1:0] {
        KIND_TICK   = 2'd0,
        KIND_ADD    = 2'd1,
        KIND_STATUS = 2'd2,
        KIND_REMOVE = 2'd3
    } kind_t;

    localparam logic [1:0] STAT_PAUSED = 2'd0;
    localparam logic [1:0] STAT_ACTIVE = 2'd1;
    localparam logic [1:0] STAT_DEAD   = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_FETCH,
        ST_FINAL,
        ST_CLEAR,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [31:0]              interval;
        logic [31:0]              interval_max;
        logic signed [PRIO_W-1:0] priority_v;
        logic                     idle_ok;
        logic [31:0]              elapsed;
    } entry_t;

endpackage

FILE: sv/ptts_if.sv
interface ptts_in_if;
    import ptts_pkg::*;
    logic              valid;
    logic              ready;
    logic [1:0]        kind;
    logic [2:0]        slot;
    logic [31:0]       norm_ival;
    logic [31:0]       max_ival;
    logic signed [5:0] nice;
    logic              use_idle;
    logic [1:0]        new_status;
    modport source (output valid, kind, slot, norm_ival, max_ival, nice, use_idle,
                    new_status, input ready);
    modport sink (input valid, kind, slot, norm_ival, max_ival, nice, use_idle,
                  new_status, output ready);
endinterface

interface ptts_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] run_mask;
    logic [3:0] run_count;
    logic [6:0] load_sum;
    logic [2:0] added_slot;
    logic       table_full;
    modport source (output valid, run_mask, run_count, load_sum, added_slot, table_full,
                    input ready);
    modport sink (input valid, run_mask, run_count, load_sum, added_slot, table_full,
                  output ready);
endinterface

interface ptts_cfg_if;
    logic        valid;
    logic        ready;
    logic [23:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

FILE: sv/ptts_ram.sv
module ptts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                 rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: sv/ptts_load.sv
module ptts_load
    import ptts_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [SCNT_W-1:0] count,
    output logic [SUM_W-1:0]  sum
);
    logic [SCNT_W-1:0] hist_reg [LOAD_WINDOW];
    logic [LPOS_W-1:0] pos_reg;
    logic [SUM_W-1:0]  sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LOAD_WINDOW; i++)
            begin
                hist_reg[i] <= (i + 1 < LOAD_WINDOW) ? SCNT_W'(1) : '0;
            end
            pos_reg <= '0;
            sum_reg <= SUM_W'(LOAD_WINDOW - 1);
        end
        else if (push)
        begin
            hist_reg[pos_reg] <= count;
            sum_reg <= sum_reg - SUM_W'(hist_reg[pos_reg]) + SUM_W'(count);
            if (32'(pos_reg) == LOAD_WINDOW - 1)
            begin
                pos_reg <= '0;
            end
            else
            begin
                pos_reg <= pos_reg + LPOS_W'(1);
            end
        end
    end

    assign sum = sum_reg;
endmodule

FILE: sv/periodic_task_tick_scheduler_top.sv
// channel | dir | handshake   | payload
// in      | in  | valid/ready | kind slot norm_ival max_ival nice use_idle new_status
// out     | out | valid/ready | run_mask run_count load_sum added_slot table_full
// cfg     | in  | valid/ready | data (tick period)
// A tick reads and then evaluates each slot in turn (READ, EVAL), then reads the winner back
// (FETCH) and clears its elapsed time (CLEAR) before FINAL and OUT.
// Add, status and remove go from the input straight to FINAL and then to OUT.
// Reset clears slot flags and presets the load history at once; the RAM needs no clearing.
// One item at a time; a new item is taken the cycle after the previous result is taken.
module periodic_task_tick_scheduler_top
    import ptts_pkg::*;
(
    input logic clk,
    input logic rst_n,
    ptts_in_if.sink   in_ch,
    ptts_out_if.source out_ch,
    ptts_cfg_if.sink  cfg
);
    state_t state_reg, state_next;
    logic [23:0] hb_reg;
    logic [SLOTS-1:0] used_reg;
    logic [1:0] status_reg [SLOTS];
    logic [1:0] kind_reg;
    logic [2:0] slot_reg;
    logic [31:0] ival_reg, imax_reg;
    logic signed [PRIO_W-1:0] nice_reg;
    logic idle_reg;
    logic [1:0] nstat_reg;
    logic [SLOT_W-1:0] idx_reg;
    logic [SLOTS-1:0] mask_reg;
    logic [SCNT_W-1:0] cnt_reg;
    logic signed [PRIO_W-1:0] wbest_reg, ibest_reg;
    logic [SLOT_W-1:0] wslot_reg, islot_reg;
    logic wfound_reg, ifound_reg;
    logic [7:0] o_mask_reg;
    logic [3:0] o_cnt_reg;
    logic [2:0] o_added_reg;
    logic o_full_reg;

    logic we;
    logic [SLOT_W-1:0] waddr, raddr;
    entry_t wdata, rdata;
    logic push;
    logic [SUM_W-1:0] sum;

    ptts_ram #(.WIDTH(ENTRY_W), .DEPTH(SLOTS)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
    );

    ptts_load u_load (.clk(clk), .rst_n(rst_n), .push(push), .count(cnt_reg), .sum(sum));

    logic free_any;
    logic [SLOT_W-1:0] free_idx;
    always_comb
    begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_any = 1'b1;
                free_idx = SLOT_W'(i);
            end
        end
    end

    logic slot_ok;
    assign slot_ok = (32'(slot_reg) < SLOTS);

    logic [32:0] sum33;
    logic part, is_max, is_wait, is_idle;
    logic last;
    logic win;
    logic [SLOT_W-1:0] win_slot;
    assign sum33 = {1'b0, rdata.elapsed} + 33'(hb_reg);
    assign part = used_reg[idx_reg] && status_reg[idx_reg] == STAT_ACTIVE;
    assign is_max = sum33 > {1'b0, rdata.interval_max};
    assign is_wait = !is_max && sum33 > {1'b0, rdata.interval};
    assign is_idle = !is_max && !is_wait && rdata.idle_ok;
    assign last = (32'(idx_reg) == SLOTS - 1);
    assign win = wfound_reg || ifound_reg;
    assign win_slot = wfound_reg ? wslot_reg : islot_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    state_next = (kind_t'(in_ch.kind) == KIND_TICK) ? ST_READ : ST_FINAL;
                end
            end
            ST_READ:  state_next = ST_EVAL;
            ST_EVAL:  state_next = last ? ST_FETCH : ST_READ;
            ST_FETCH: state_next = ST_CLEAR;
            ST_CLEAR: state_next = ST_FINAL;
            ST_FINAL: state_next = ST_OUT;
            ST_OUT:   if (out_ch.ready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        we = 1'b0;
        waddr = idx_reg;
        raddr = idx_reg;
        wdata = rdata;
        push = 1'b0;
        unique case (state_reg)
            ST_EVAL:
            begin
                if (part && !is_wait && !is_idle)
                begin
                    we = 1'b1;
                    wdata.elapsed = is_max ? 32'd0 :
                        (sum33[32] ? ELAPSED_MAX : sum33[31:0]);
                end
            end
            ST_FETCH:
            begin
                raddr = win_slot;
            end
            ST_CLEAR:
            begin
                if (win)
                begin
                    we = 1'b1;
                    waddr = win_slot;
                    wdata.elapsed = 32'd0;
                end
            end
            ST_FINAL:
            begin
                push = (kind_t'(kind_reg) == KIND_TICK);
                if (kind_t'(kind_reg) == KIND_ADD && free_any)
                begin
                    we = 1'b1;
                    waddr = free_idx;
                    wdata.interval = ival_reg;
                    wdata.interval_max = imax_reg;
                    wdata.priority_v = nice_reg;
                    wdata.idle_ok = idle_reg;
                    wdata.elapsed = 32'd0;
                end
            end
            default: ;
        endcase
    end

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign cfg.ready = 1'b1;
    assign out_ch.valid = (state_reg == ST_OUT);
    assign out_ch.run_mask = o_mask_reg;
    assign out_ch.run_count = o_cnt_reg;
    assign out_ch.load_sum = 7'(sum);
    assign out_ch.added_slot = o_added_reg;
    assign out_ch.table_full = o_full_reg;

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && state_reg == ST_IDLE)
        begin
            kind_reg <= in_ch.kind;
            slot_reg <= in_ch.slot;
            ival_reg <= in_ch.norm_ival;
            imax_reg <= in_ch.max_ival;
            nice_reg <= in_ch.nice;
            idle_reg <= in_ch.use_idle;
            nstat_reg <= in_ch.new_status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            hb_reg <= HEARTBEAT_RESET;
            used_reg <= '0;
            for (int i = 0; i < SLOTS; i++)
            begin
                status_reg[i] <= STAT_PAUSED;
            end
            idx_reg <= '0;
            mask_reg <= '0;
            cnt_reg <= '0;
            wbest_reg <= NO_WIN_PRIORITY;
            ibest_reg <= NO_WIN_PRIORITY;
            wslot_reg <= '0;
            islot_reg <= '0;
            wfound_reg <= 1'b0;
            ifound_reg <= 1'b0;
            o_mask_reg <= '0;
            o_cnt_reg <= '0;
            o_added_reg <= '0;
            o_full_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid)
            begin
                hb_reg <= cfg.data;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    idx_reg <= '0;
                    mask_reg <= '0;
                    cnt_reg <= '0;
                    wbest_reg <= NO_WIN_PRIORITY;
                    ibest_reg <= NO_WIN_PRIORITY;
                    wfound_reg <= 1'b0;
                    ifound_reg <= 1'b0;
                end
                ST_EVAL:
                begin
                    if (part)
                    begin
                        if (is_max)
                        begin
                            mask_reg[idx_reg] <= 1'b1;
                            cnt_reg <= cnt_reg + SCNT_W'(1);
                        end
                        else if (is_wait && rdata.priority_v < wbest_reg)
                        begin
                            wbest_reg <= rdata.priority_v;
                            wslot_reg <= idx_reg;
                            wfound_reg <= 1'b1;
                        end
                        else if (is_idle && rdata.priority_v < ibest_reg)
                        begin
                            ibest_reg <= rdata.priority_v;
                            islot_reg <= idx_reg;
                            ifound_reg <= 1'b1;
                        end
                    end
                    if (!last)
                    begin
                        idx_reg <= idx_reg + SLOT_W'(1);
                    end
                end
                ST_CLEAR:
                begin
                    if (win)
                    begin
                        mask_reg[win_slot] <= 1'b1;
                        cnt_reg <= cnt_reg + SCNT_W'(1);
                    end
                end
                ST_FINAL:
                begin
                    o_mask_reg <= '0;
                    o_cnt_reg <= '0;
                    o_added_reg <= '0;
                    o_full_reg <= 1'b0;
                    unique case (kind_t'(kind_reg))
                        KIND_TICK:
                        begin
                            for (int i = 0; i < SLOTS && i < 8; i++)
                            begin
                                o_mask_reg[i] <= mask_reg[i];
                            end
                            o_cnt_reg <= 4'(cnt_reg);
                        end
                        KIND_ADD:
                        begin
                            if (free_any)
                            begin
                                used_reg[free_idx] <= 1'b1;
                                status_reg[free_idx] <= STAT_PAUSED;
                                o_added_reg <= 3'(free_idx);
                            end
                            else
                            begin
                                o_full_reg <= 1'b1;
                            end
                        end
                        KIND_STATUS:
                        begin
                            if (slot_ok && used_reg[SLOT_W'(slot_reg)])
                            begin
                                status_reg[SLOT_W'(slot_reg)] <= nstat_reg;
                            end
                        end
                        KIND_REMOVE:
                        begin
                            if (slot_ok)
                            begin
                                used_reg[SLOT_W'(slot_reg)] <= 1'b0;
                                status_reg[SLOT_W'(slot_reg)] <= STAT_DEAD;
                            end
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end
endmodule

FILE: tb/periodic_task_tick_scheduler_top_tb.sv
module periodic_task_tick_scheduler_top_tb;
    import ptts_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE      = 40;

    typedef struct {
        kind_t              kind;
        logic [2:0]         slot;
        logic [31:0]        ivl;
        logic [31:0]        ivl_max;
        logic signed [5:0]  nice;
        logic               use_idle;
        logic [1:0]         new_status;
    } task_cmd_t;

    typedef struct {
        logic [7:0] run_mask;
        logic [3:0] run_count;
        logic [6:0] load_sum;
        logic [2:0] added_slot;
        logic       table_full;
    } sched_res_t;

    class sched_board;
        logic [23:0]       heartbeat;
        bit                used [SLOTS];
        logic [1:0]        status [SLOTS];
        logic [31:0]       ivl [SLOTS];
        logic [31:0]       ivl_max [SLOTS];
        int                prio [SLOTS];
        bit                idle_ok [SLOTS];
        logic [31:0]       elapsed [SLOTS];
        int                history [LOAD_WINDOW];
        int                hpos;
        sched_res_t        pending [$];
        int                errors;
        int                ticks;
        int                grants;
        int                fulls;
        int                checked;

        function new();
            heartbeat = HEARTBEAT_RESET;
            for (int i = 0; i < SLOTS; i++)
            begin
                used[i] = 0;
                status[i] = STAT_PAUSED;
                elapsed[i] = 0;
            end
            for (int i = 0; i < LOAD_WINDOW; i++)
                history[i] = (i + 1 < LOAD_WINDOW) ? 1 : 0;
            hpos = 0;
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
            errors++;
        endtask

        function sched_res_t run_tick();
            sched_res_t r;
            logic [32:0] sum;
            int wbest, ibest, wslot, islot, cnt;
            r = '{default: '0};
            wbest = 20;
            ibest = 20;
            wslot = -1;
            islot = -1;
            cnt = 0;
            for (int i = 0; i < SLOTS; i++)
            begin
                if (!used[i] || status[i] != STAT_ACTIVE)
                    continue;
                sum = {1'b0, elapsed[i]} + {9'b0, heartbeat};
                if (sum > {1'b0, ivl_max[i]})
                begin
                    elapsed[i] = 0;
                    r.run_mask[i] = 1'b1;
                    cnt++;
                end
                else if (sum > {1'b0, ivl[i]})
                begin
                    if (prio[i] < wbest)
                    begin
                        wbest = prio[i];
                        wslot = i;
                    end
                end
                else if (idle_ok[i])
                begin
                    if (prio[i] < ibest)
                    begin
                        ibest = prio[i];
                        islot = i;
                    end
                end
                else
                    elapsed[i] = sum[32] ? ELAPSED_MAX : sum[31:0];
            end
            if (wslot < 0)
                wslot = islot;
            if (wslot >= 0)
            begin
                elapsed[wslot] = 0;
                r.run_mask[wslot] = 1'b1;
                cnt++;
            end
            history[hpos] = cnt;
            hpos = (hpos + 1) % LOAD_WINDOW;
            r.run_count = 4'(cnt);
            ticks++;
            grants += cnt;
            return r;
        endfunction

        function void note_input(task_cmd_t c);
            sched_res_t r;
            int s, free_slot;
            r = '{default: '0};
            s = c.slot;
            case (c.kind)
                KIND_TICK: r = run_tick();
                KIND_ADD:
                begin
                    free_slot = -1;
                    for (int i = SLOTS - 1; i >= 0; i--)
                        if (!used[i])
                            free_slot = i;
                    if (free_slot < 0)
                    begin
                        r.table_full = 1'b1;
                        fulls++;
                    end
                    else
                    begin
                        used[free_slot] = 1;
                        status[free_slot] = STAT_PAUSED;
                        ivl[free_slot] = c.ivl;
                        ivl_max[free_slot] = c.ivl_max;
                        prio[free_slot] = c.nice;
                        idle_ok[free_slot] = c.use_idle;
                        elapsed[free_slot] = 0;
                        r.added_slot = 3'(free_slot);
                    end
                end
                KIND_STATUS:
                    if (s < SLOTS && used[s])
                        status[s] = c.new_status;
                default:
                    if (s < SLOTS)
                    begin
                        used[s] = 0;
                        status[s] = STAT_DEAD;
                    end
            endcase
            s = 0;
            for (int i = 0; i < LOAD_WINDOW; i++)
                s += history[i];
            r.load_sum = 7'(s);
            pending.push_back(r);
        endfunction

        task check_result(sched_res_t got);
            sched_res_t want;
            checked++;
            if (pending.size() == 0)
            begin
                report("unexpected item", 0, 0);
                return;
            end
            want = pending.pop_front();
            if (got.run_mask !== want.run_mask)
                report("run_mask", got.run_mask, want.run_mask);
            if (got.run_count !== want.run_count)
                report("run_count", got.run_count, want.run_count);
            if (got.load_sum !== want.load_sum)
                report("load_sum", got.load_sum, want.load_sum);
            if (got.added_slot !== want.added_slot)
                report("added_slot", got.added_slot, want.added_slot);
            if (got.table_full !== want.table_full)
                report("table_full", got.table_full, want.table_full);
        endtask
    endclass

    logic clk;
    logic rst_n;
    int   cycles;
    bit   quiet;
    bit   long_hold;
    int   sent;

    sched_board board = new();

    ptts_in_if  in_ch ();
    ptts_out_if out_ch ();
    ptts_cfg_if cfg ();

    periodic_task_tick_scheduler_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        sched_res_t r;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            r.run_mask = out_ch.run_mask;
            r.run_count = out_ch.run_count;
            r.load_sum = out_ch.load_sum;
            r.added_slot = out_ch.added_slot;
            r.table_full = out_ch.table_full;
            board.check_result(r);
        end
    end

    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                out_ch.ready <= 1'b0;
                repeat (400) @(posedge clk);
                long_hold = 0;
            end
            else if (!quiet && $urandom_range(0, 3) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 18) - 1) @(posedge clk);
            end
            else
            begin
                out_ch.ready <= 1'b1;
                repeat ($urandom_range(0, 20)) @(posedge clk);
            end
        end
    end

    task automatic send_cmd(task_cmd_t c);
        in_ch.valid <= 1'b1;
        in_ch.kind <= c.kind;
        in_ch.slot <= c.slot;
        in_ch.norm_ival <= c.ivl;
        in_ch.max_ival <= c.ivl_max;
        in_ch.nice <= c.nice;
        in_ch.use_idle <= c.use_idle;
        in_ch.new_status <= c.new_status;
        do
            @(posedge clk);
        while (!in_ch.ready);
        board.note_input(c);
        sent++;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_heartbeat(logic [23:0] hb);
        drain();
        cfg.valid <= 1'b1;
        cfg.data <= hb;
        do
            @(posedge clk);
        while (!cfg.ready);
        cfg.valid <= 1'b0;
        board.heartbeat = hb;
    endtask

    function automatic task_cmd_t make_cmd(kind_t k, int slot, logic [31:0] ivl,
                                           logic [31:0] ivl_max, int nice, bit idle,
                                           int st);
        task_cmd_t c;
        c.kind = k;
        c.slot = 3'(slot);
        c.ivl = ivl;
        c.ivl_max = ivl_max;
        c.nice = 6'(nice);
        c.use_idle = idle;
        c.new_status = 2'(st);
        return c;
    endfunction

    function automatic logic [31:0] scaled(int lo, int hi);
        longint unsigned v;
        v = longint'(board.heartbeat) * $urandom_range(lo, hi) + $urandom_range(0, 3);
        return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    function automatic task_cmd_t random_cmd();
        task_cmd_t c;
        int pick;
        c.slot = 3'($urandom_range(0, 7));
        c.nice = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, 63) - 32)
                                              : 6'($urandom_range(0, 40) - 20);
        c.use_idle = 1'($urandom_range(0, 1));
        c.new_status = ($urandom_range(0, 2) != 0) ? STAT_ACTIVE : 2'($urandom_range(0, 3));
        if ($urandom_range(0, 4) == 0)
        begin
            c.ivl = $urandom;
            c.ivl_max = $urandom;
        end
        else
        begin
            c.ivl = scaled(0, 8);
            c.ivl_max = c.ivl + scaled(0, 12);
            if (c.ivl_max < c.ivl)
                c.ivl_max = 32'hFFFF_FFFF;
        end
        pick = $urandom_range(0, 99);
        if (pick < 50)
            c.kind = KIND_TICK;
        else if (pick < 66)
            c.kind = KIND_ADD;
        else if (pick < 90)
            c.kind = KIND_STATUS;
        else
            c.kind = KIND_REMOVE;
        return c;
    endfunction

    task automatic random_run(int n);
        for (int i = 0; i < n; i++)
            send_cmd(random_cmd());
    endtask

    initial
    begin
        clk = 1'b0;
        cycles = 0;
        quiet = 0;
        long_hold = 0;
        sent = 0;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.kind = KIND_TICK;
        in_ch.slot = '0;
        in_ch.norm_ival = '0;
        in_ch.max_ival = '0;
        in_ch.nice = '0;
        in_ch.use_idle = 1'b0;
        in_ch.new_status = '0;
        cfg.valid = 1'b0;
        cfg.data = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_cmd(make_cmd(KIND_TICK, 0, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(KIND_ADD, 0, 0, 0, -20, 0, 0));
        send_cmd(make_cmd(KIND_ADD, 7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 31, 1, 3));
        send_cmd(make_cmd(KIND_ADD, 0, 1500, 5000, 20, 1, 0));
        send_cmd(make_cmd(KIND_ADD, 0, 1500, 5000, -32, 0, 0));
        send_cmd(make_cmd(KIND_ADD, 0, 2500, 3500, 5, 1, 0));
        send_cmd(make_cmd(KIND_ADD, 0, 500, 9000, 5, 0, 0));
        send_cmd(make_cmd(KIND_ADD, 0, 3000, 6000, 0, 1, 0));
        send_cmd(make_cmd(KIND_ADD, 0, 8000, 8000, -1, 0, 0));
        send_cmd(make_cmd(KIND_ADD, 0, 1, 1, 1, 1, 0));
        for (int s = 0; s < SLOTS; s++)
            send_cmd(make_cmd(KIND_STATUS, s, 0, 0, 0, 0, (s == 6) ? 3 : STAT_ACTIVE));
        send_cmd(make_cmd(KIND_TICK, 0, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(KIND_TICK, 0, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(KIND_REMOVE, 3, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(KIND_REMOVE, 3, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(KIND_STATUS, 3, 0, 0, 0, 0, STAT_ACTIVE));
        send_cmd(make_cmd(KIND_STATUS, 2, 0, 0, 0, 0, STAT_DEAD));
        send_cmd(make_cmd(KIND_TICK, 0, 0, 0, 0, 0, 0));

        random_run(300);
        write_heartbeat(24'd1);
        long_hold = 1;
        random_run(300);
        write_heartbeat(24'hFF_FFFF);
        random_run(300);
        write_heartbeat(24'($urandom_range(1, 24'hFF_FFFF)));
        random_run(300);
        write_heartbeat(24'd1000);
        quiet = 1;
        random_run(300);

        drain();
        $display("scheduler: %0d items sent, %0d results checked, %0d ticks, %0d grants",
                 sent, board.checked, board.ticks, board.grants);
        $display("scheduler: %0d adds hit a full table, heartbeat settings 1 to 16777215",
                 board.fulls);
        if (board.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

FILE: filelist.f
sv/ptts_pkg.sv
sv/ptts_if.sv
sv/ptts_ram.sv
sv/ptts_load.sv
sv/periodic_task_tick_scheduler_top.sv
tb/periodic_task_tick_scheduler_top_tb.sv
